FILE: rtl/holiday_day_colour_unit_macros.svh
// ---------------------------------------------------------------------------
// holiday_day_colour_unit_macros.svh - assertion helpers
// Concurrent assertion shorthands; clk_i and rst_ni must be in scope.
// ---------------------------------------------------------------------------
`ifndef HOLIDAY_DAY_COLOUR_UNIT_MACROS_SVH
`define HOLIDAY_DAY_COLOUR_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication, disabled while in reset
`define HDC_ASSERT_LAT5(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##5 (cons)) \
    else $error(msg);

`endif

FILE: rtl/hdc_pkg.sv
// ---------------------------------------------------------------------------
// hdc_pkg - holiday day colour package
// Colour codes, calendar tables and constant-divisor helpers.
// ---------------------------------------------------------------------------
package hdc_pkg;

  typedef enum logic [1:0] {
    COL_ERROR = 2'd0,
    COL_BLACK = 2'd1,
    COL_PINK  = 2'd2,
    COL_RED   = 2'd3
  } colour_e;

  localparam logic [11:0] YEAR_MIN = 12'd1980;
  localparam logic [11:0] YEAR_MAX = 12'd2099;

  // weekday codes
  localparam logic [2:0] WD_SUNDAY   = 3'd0;
  localparam logic [2:0] WD_FRIDAY   = 3'd5;
  localparam logic [2:0] WD_SATURDAY = 3'd6;

  // v mod 7 for v < 128: reciprocal estimate, one correction
  function automatic logic [2:0] mod7_7b(input logic [6:0] v);
    logic [12:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = {6'b0, v} * 13'd36;
    q = p[12:8];
    r = {1'b0, v} - ({3'b0, q} * 8'd7);
    if (r >= 8'd7) r = r - 8'd7;
    return r[2:0];
  endfunction

  // v mod 19 for v < 128
  function automatic logic [4:0] mod19_7b(input logic [6:0] v);
    logic [11:0] p;
    logic [2:0]  q;
    logic [7:0]  r;
    p = {5'b0, v} * 12'd26;
    q = p[11:9];
    r = {1'b0, v} - ({5'b0, q} * 8'd19);
    if (r >= 8'd19) r = r - 8'd19;
    return r[4:0];
  endfunction

  // v / 10 for v < 128, exact
  function automatic logic [3:0] div10_7b(input logic [6:0] v);
    logic [14:0] p;
    p = {8'b0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] l;
    unique case (m)
      4'd2:                    l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
      default:                 l = 5'd31;
    endcase
    return l;
  endfunction

  // days before the month, non-leap
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] o;
    unique case (m)
      4'd2:    o = 9'd31;
      4'd3:    o = 9'd59;
      4'd4:    o = 9'd90;
      4'd5:    o = 9'd120;
      4'd6:    o = 9'd151;
      4'd7:    o = 9'd181;
      4'd8:    o = 9'd212;
      4'd9:    o = 9'd243;
      4'd10:   o = 9'd273;
      4'd11:   o = 9'd304;
      4'd12:   o = 9'd334;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

  function automatic logic [2:0] decade_corr(input logic [3:0] dec);
    logic [2:0] k;
    unique case (dec)
      4'd1:    k = 3'd5;
      4'd2:    k = 3'd4;
      4'd3:    k = 3'd2;
      4'd4:    k = 3'd1;
      4'd5:    k = 3'd6;
      4'd6:    k = 3'd5;
      4'd7:    k = 3'd3;
      4'd8:    k = 3'd2;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  // year-digit correction; odd decades use the second row
  function automatic logic [2:0] digit_corr(input logic [3:0] dig, input logic odd);
    logic [2:0] k;
    unique case (dig)
      4'd1:    k = 3'd1;
      4'd2:    k = odd ? 3'd3 : 3'd2;
      4'd3:    k = odd ? 3'd4 : 3'd3;
      4'd4:    k = 3'd5;
      4'd5:    k = 3'd6;
      4'd6:    k = odd ? 3'd1 : 3'd0;
      4'd7:    k = odd ? 3'd2 : 3'd1;
      4'd8:    k = 3'd3;
      4'd9:    k = 3'd4;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] month_corr(input logic [3:0] m, input logic leap);
    logic [2:0] k;
    unique case (m)
      4'd1:    k = leap ? 3'd6 : 3'd0;
      4'd2:    k = leap ? 3'd2 : 3'd3;
      4'd4:    k = 3'd6;
      4'd5:    k = 3'd1;
      4'd6:    k = 3'd4;
      4'd7:    k = 3'd6;
      4'd8:    k = 3'd2;
      4'd9:    k = 3'd5;
      4'd10:   k = 3'd0;
      4'd12:   k = 3'd5;
      default: k = 3'd3;
    endcase
    return k;
  endfunction

  // (19*a + 24) mod 30 for a = year mod 19
  function automatic logic [4:0] gauss_d(input logic [4:0] a);
    logic [4:0] d;
    unique case (a)
      5'd0:    d = 5'd24;
      5'd1:    d = 5'd13;
      5'd2:    d = 5'd2;
      5'd3:    d = 5'd21;
      5'd4:    d = 5'd10;
      5'd5:    d = 5'd29;
      5'd6:    d = 5'd18;
      5'd7:    d = 5'd7;
      5'd8:    d = 5'd26;
      5'd9:    d = 5'd15;
      5'd10:   d = 5'd4;
      5'd11:   d = 5'd23;
      5'd12:   d = 5'd12;
      5'd13:   d = 5'd1;
      5'd14:   d = 5'd20;
      5'd15:   d = 5'd9;
      5'd16:   d = 5'd28;
      5'd17:   d = 5'd17;
      5'd18:   d = 5'd6;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/hdc_easter.sv
// ---------------------------------------------------------------------------
// hdc_easter - Easter Sunday day number
// Two-stage Gauss computation; day number is non-leap, counted from Jan 1 = 1.
// ---------------------------------------------------------------------------
module hdc_easter (
  input  logic       clk_i,
  input  logic [4:0] a_i,    // year mod 19
  input  logic [1:0] b_i,    // year mod 4
  input  logic [2:0] c_i,    // year mod 7
  output logic [7:0] eo_o
);

  logic [4:0] dd_d, dd_q;
  logic [2:0] dd7_d, dd7_q;
  logic [1:0] b_q;
  logic [2:0] c_q;
  logic       a_hi_d, a_hi_q;

  logic [6:0] esum;
  logic [2:0] e;
  logic [7:0] eo_d, eo_q;

  // stage 1: table lookup
  assign dd_d   = hdc_pkg::gauss_d(a_i);
  assign dd7_d  = hdc_pkg::mod7_7b({2'b0, dd_d});
  assign a_hi_d = (a_i > 5'd10);

  always_ff @(posedge clk_i) begin
    dd_q   <= dd_d;
    dd7_q  <= dd7_d;
    b_q    <= b_i;
    c_q    <= c_i;
    a_hi_q <= a_hi_d;
  end

  // stage 2: e = (2b + 4c + 6d + 5) mod 7, then March 22 + d + e
  assign esum = {4'b0, b_q, 1'b0} + {2'b0, c_q, 2'b0} +
                ({4'b0, dd7_q} * 7'd6) + 7'd5;
  assign e    = hdc_pkg::mod7_7b(esum);

  always_comb begin
    eo_d = 8'd81 + {3'b0, dd_q} + {5'b0, e};
    if (dd_q == 5'd29 && e == 3'd6) eo_d = 8'd109;                // Apr 19
    if (dd_q == 5'd28 && e == 3'd6 && a_hi_q) eo_d = 8'd108;      // Apr 18
  end

  always_ff @(posedge clk_i) begin
    eo_q <= eo_d;
  end

  assign eo_o = eo_q;

endmodule

FILE: rtl/holiday_day_colour_unit.sv
// ---------------------------------------------------------------------------
// holiday_day_colour_unit - Swedish calendar day colour
// Classifies a date as error, black, pink (eve / Saturday) or red.
// ---------------------------------------------------------------------------
// A date beat is taken on every cycle with start_i high (busy_o is never
// raised). Its colour is on colour_o with valid_o high for one cycle only,
// after the beat has passed through the five register stages. The receiver
// cannot stall, so nothing is buffered: one beat in per cycle, one beat out
// per cycle, in order. The stages are:
//   S1 range checks, year offset, day-of-year
//   S2 decade/digit split, year mod 19 / mod 7, month correction
//   S3 weekday sum mod 7; Easter table lookup
//   S4 Easter day number (Gauss)
//   S5 rule priority and output register
// Years outside 1980..2099, months outside 1..12 and day 0 or past month end
// give the error colour. Leap years are every fourth year.
// ---------------------------------------------------------------------------
`include "holiday_day_colour_unit_macros.svh"

module holiday_day_colour_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  output logic        valid_o,
  output logic [1:0]  colour_o
);

  // ---------------- valid chain ----------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  // ---------------- S1 ----------------
  logic        year_ok, month_ok, day_ok, leap;
  logic [4:0]  mlen;
  logic [11:0] off_full;
  logic [6:0]  off, rem;
  logic        cent;
  logic [8:0]  oday;

  assign year_ok  = (year_i >= hdc_pkg::YEAR_MIN) && (year_i <= hdc_pkg::YEAR_MAX);
  assign month_ok = (month_i >= 4'd1) && (month_i <= 4'd12);
  assign leap     = (year_i[1:0] == 2'b00);
  assign mlen     = (month_i == 4'd2 && leap) ? 5'd29 : hdc_pkg::month_len(month_i);
  assign day_ok   = (day_of_month_i != 5'd0) && (day_of_month_i <= mlen);
  assign off_full = year_i - hdc_pkg::YEAR_MIN;
  assign off      = off_full[6:0];
  assign cent     = (off >= 7'd20);                    // 2000 and later
  assign rem      = cent ? (off - 7'd20) : (off + 7'd80); // two-digit year
  assign oday     = hdc_pkg::days_before(month_i) + {4'b0, day_of_month_i};

  logic       s1_err_q, s1_leap_q, s1_cent_q;
  logic [6:0] s1_off_q, s1_rem_q;
  logic [3:0] s1_m_q;
  logic [4:0] s1_d_q;
  logic [8:0] s1_oday_q;
  logic [1:0] s1_b_q;

  always_ff @(posedge clk_i) begin
    s1_err_q  <= !(year_ok && month_ok && day_ok);
    s1_leap_q <= leap;
    s1_cent_q <= cent;
    s1_off_q  <= off;
    s1_rem_q  <= rem;
    s1_m_q    <= month_i;
    s1_d_q    <= day_of_month_i;
    s1_oday_q <= oday;
    s1_b_q    <= year_i[1:0];
  end

  // ---------------- S2 ----------------
  logic [3:0] dec, dig;
  logic [7:0] dig_full;

  assign dec      = hdc_pkg::div10_7b(s1_rem_q);
  assign dig_full = {1'b0, s1_rem_q} - ({4'b0, dec} * 8'd10);
  assign dig      = dig_full[3:0];

  logic       s2_err_q, s2_cent_q;
  logic [2:0] s2_kdec_q, s2_kdig_q, s2_km_q;
  logic [3:0] s2_m_q;
  logic [4:0] s2_d_q;
  logic [8:0] s2_oday_q;
  logic [4:0] s2_a_q;
  logic [1:0] s2_b_q;
  logic [2:0] s2_c_q;

  // 1980 mod 19 = 4, 1980 mod 7 = 6
  always_ff @(posedge clk_i) begin
    s2_err_q  <= s1_err_q;
    s2_cent_q <= s1_cent_q;
    s2_kdec_q <= hdc_pkg::decade_corr(dec);
    s2_kdig_q <= hdc_pkg::digit_corr(dig, dec[0]);
    s2_km_q   <= hdc_pkg::month_corr(s1_m_q, s1_leap_q);
    s2_m_q    <= s1_m_q;
    s2_d_q    <= s1_d_q;
    s2_oday_q <= s1_oday_q;
    s2_a_q    <= hdc_pkg::mod19_7b(s1_off_q + 7'd4);
    s2_b_q    <= s1_b_q;
    s2_c_q    <= hdc_pkg::mod7_7b(s1_off_q + 7'd6);
  end

  // ---------------- S3 / S4 ----------------
  logic [6:0] wd_sum;
  assign wd_sum = (s2_cent_q ? 7'd6 : 7'd0) + {4'b0, s2_kdec_q} + {4'b0, s2_kdig_q} +
                  {4'b0, s2_km_q} + {2'b0, s2_d_q};

  logic       s3_err_q, s4_err_q;
  logic [2:0] s3_wd_q, s4_wd_q;
  logic [3:0] s3_m_q, s4_m_q;
  logic [4:0] s3_d_q, s4_d_q;
  logic [8:0] s3_oday_q, s4_oday_q;

  always_ff @(posedge clk_i) begin
    s3_err_q  <= s2_err_q;
    s3_wd_q   <= hdc_pkg::mod7_7b(wd_sum);
    s3_m_q    <= s2_m_q;
    s3_d_q    <= s2_d_q;
    s3_oday_q <= s2_oday_q;
    s4_err_q  <= s3_err_q;
    s4_wd_q   <= s3_wd_q;
    s4_m_q    <= s3_m_q;
    s4_d_q    <= s3_d_q;
    s4_oday_q <= s3_oday_q;
  end

  // Easter day number lands in step with the S4 registers
  logic [7:0] eo;

  hdc_easter u_easter (
    .clk_i (clk_i),
    .a_i   (s2_a_q),
    .b_i   (s2_b_q),
    .c_i   (s2_c_q),
    .eo_o  (eo)
  );

  // ---------------- S5: rule priority ----------------
  logic [9:0] o10, e10;
  assign o10 = {1'b0, s4_oday_q};
  assign e10 = {2'b0, eo};

  logic is_sun, is_fri, is_sat;
  assign is_sun = (s4_wd_q == hdc_pkg::WD_SUNDAY);
  assign is_fri = (s4_wd_q == hdc_pkg::WD_FRIDAY);
  assign is_sat = (s4_wd_q == hdc_pkg::WD_SATURDAY);

  hdc_pkg::colour_e col_d, col_q;

  always_comb begin
    col_d = is_sat ? hdc_pkg::COL_PINK : hdc_pkg::COL_BLACK;
    // Easter-linked days, March to June only
    if (s4_m_q >= 4'd3 && s4_m_q <= 4'd6) begin
      if      (o10 == e10 + 10'd1)  col_d = hdc_pkg::COL_RED;   // Easter Monday
      else if (o10 + 10'd1 == e10)  col_d = hdc_pkg::COL_PINK;  // Easter Eve
      else if (o10 + 10'd2 == e10)  col_d = hdc_pkg::COL_RED;   // Good Friday
      else if (o10 + 10'd3 == e10)  col_d = hdc_pkg::COL_PINK;  // Maundy Thursday
      else if (o10 == e10 + 10'd39) col_d = hdc_pkg::COL_RED;   // Ascension
      else if (o10 == e10 + 10'd38) col_d = hdc_pkg::COL_PINK;
      else if (o10 == e10 + 10'd48) col_d = hdc_pkg::COL_PINK;  // Whitsun eve
      else if (o10 == e10 + 10'd50) col_d = hdc_pkg::COL_RED;
    end
    // All Saints window
    if (s4_m_q == 4'd11 && s4_d_q <= 5'd6 && is_sat)  col_d = hdc_pkg::COL_RED;
    if (s4_m_q == 4'd11 && s4_d_q <= 5'd5 && is_fri)  col_d = hdc_pkg::COL_PINK;
    if (s4_m_q == 4'd10 && s4_d_q >= 5'd31 && is_sat) col_d = hdc_pkg::COL_RED;
    if (s4_m_q == 4'd10 && s4_d_q >= 5'd30 && is_fri) col_d = hdc_pkg::COL_PINK;
    // Midsummer window
    if (s4_m_q == 4'd6 && s4_d_q >= 5'd20 && s4_d_q <= 5'd26 && is_sat)
      col_d = hdc_pkg::COL_RED;
    if (s4_m_q == 4'd6 && s4_d_q >= 5'd19 && s4_d_q <= 5'd25 && is_fri)
      col_d = hdc_pkg::COL_PINK;
    // fixed dates
    if (s4_m_q == 4'd12 && s4_d_q == 5'd31) col_d = hdc_pkg::COL_PINK;
    if (s4_m_q == 4'd12 && (s4_d_q == 5'd25 || s4_d_q == 5'd26)) col_d = hdc_pkg::COL_RED;
    if (s4_m_q == 4'd12 && s4_d_q == 5'd24) col_d = hdc_pkg::COL_PINK;
    if (s4_m_q == 4'd5  && s4_d_q == 5'd1)  col_d = hdc_pkg::COL_RED;
    if (s4_m_q == 4'd4  && s4_d_q == 5'd30) col_d = hdc_pkg::COL_PINK;
    if (s4_m_q == 4'd1  && s4_d_q == 5'd6)  col_d = hdc_pkg::COL_RED;
    if (s4_m_q == 4'd1  && s4_d_q == 5'd5)  col_d = hdc_pkg::COL_PINK;
    if (s4_m_q == 4'd1  && s4_d_q == 5'd1)  col_d = hdc_pkg::COL_RED;
    // highest priority last
    if (is_sun)   col_d = hdc_pkg::COL_RED;
    if (s4_err_q) col_d = hdc_pkg::COL_ERROR;
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign busy_o   = 1'b0;
  assign valid_o  = out_vld_q;
  assign colour_o = col_q;

  // ---------------- assertions ----------------
  // any in-range January date with a nonzero day is a real date
  logic jan_date_in;
  assign jan_date_in = start_i && year_ok && (month_i == 4'd1) && (day_of_month_i != 5'd0);

  `HDC_ASSERT_LAT5(a_lat_fwd, start_i && !busy_o, valid_o, "date beat lost in pipeline")
  `HDC_ASSERT_IMP(a_lat_bwd, valid_o, $past(start_i, 5), "result beat without a date")
  `HDC_ASSERT_LAT5(a_jan_ok, jan_date_in, colour_o != hdc_pkg::COL_ERROR, "January date flagged")
  `HDC_ASSERT_LAT5(a_bad_month, start_i && month_i == 4'd0, colour_o == hdc_pkg::COL_ERROR, "month zero not flagged")

endmodule
